@@ rtl/cas_pkg.sv @@
package cas_pkg;

    localparam int unsigned USAGE_W    = 8;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned ENTRY_W    = USAGE_W + DUR_W;

    localparam logic [USAGE_W-1:0] CAPACITY_RESET = 8'd100;
    localparam logic [TIME_W-1:0]  TIME_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_DECIDE,
        ST_UPDATE,
        ST_ADMIT,
        ST_REJECT
    } state_t;

endpackage

@@ rtl/capacity_admission_scheduler.sv @@
// Admission scheduler for jobs sharing one resource capacity. Each input beat is a job
// (usage, duration); each job gives exactly one output beat with its start time, or
// rejected=1 and start_time=0 when its usage alone is above the capacity. Accepted jobs
// sit in a table of SLOTS entries; while the job does not fit (capacity or table full)
// the block retires the jobs with the least remaining time and advances its clock by
// that time, which saturates at its maximum. An admitted job takes one search pass over the
// table, plus an update pass and a search pass for each completion step it needs, since every
// step streams all slots through the single read port of the slot memory twice. The capacity
// register (reset 100) is to be written through the cfg port only while idle; the user must
// keep to this, as the block itself does not enforce it (cfg_ready is always 1). A new
// job is taken as soon as the previous one has left the scheduler, and its result may
// still wait in the output register.
module capacity_admission_scheduler
    import cas_pkg::*;
#(
    parameter int unsigned SLOTS = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [USAGE_W-1:0]   cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [USAGE_W-1:0]   s_job_usage,
    input  logic [DUR_W-1:0]     s_job_duration,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TIME_W-1:0]    m_start_time,
    output logic                 m_rejected
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SCAN_END = CW'(SLOTS);

    state_t state_reg, state_next;

    logic [ENTRY_W-1:0]  slot_mem [SLOTS];
    logic [ENTRY_W-1:0]  mem_q_reg;
    logic [SLOTS-1:0]    active_reg;

    logic [USAGE_W-1:0]  capacity_reg;
    logic [USAGE_W-1:0]  used_reg, used_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [USAGE_W-1:0]  job_usage_reg;
    logic [DUR_W-1:0]    job_dur_reg;

    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                p_vld_reg;
    logic [IW-1:0]       p_idx_reg;
    logic                least_vld_reg, least_vld_next;
    logic [DUR_W-1:0]    least_reg, least_next;
    logic                free_vld_reg, free_vld_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;

    logic                m_valid_reg, m_valid_next;
    logic [TIME_W-1:0]   m_start_reg, m_start_next;
    logic                m_rej_reg, m_rej_next;

    // control
    logic                in_fire;
    logic                out_free;
    logic                scan_issue;
    logic                scan_done;
    logic                scan_clr;
    logic                scan_rewind;
    logic                fits;
    logic                admit_fire;
    logic                reject_fire;
    logic                upd_retire;
    logic                upd_write;

    // datapath views
    logic                act_q;
    logic [USAGE_W-1:0]  q_usage;
    logic [DUR_W-1:0]    q_rem;
    logic [TIME_W:0]     time_sum;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;

    assign act_q    = active_reg[p_idx_reg];
    assign q_usage  = mem_q_reg[ENTRY_W-1:DUR_W];
    assign q_rem    = mem_q_reg[DUR_W-1:0];
    assign time_sum = {1'b0, time_reg} + (TIME_W + 1)'(least_reg);

    assign out_free  = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign scan_done = (scan_cnt_reg == SCAN_END) && !p_vld_reg;
    assign fits      = free_vld_reg
                       && (({1'b0, used_reg} + {1'b0, job_usage_reg}) <= {1'b0, capacity_reg});

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_start_time = m_start_reg;
    assign m_rejected   = m_rej_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_job_usage > capacity_reg) ? ST_REJECT : ST_FIND;
                end
            end
            ST_FIND: begin
                if (scan_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (fits || !least_vld_reg) state_next = ST_ADMIT;
                else state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (scan_done) state_next = ST_FIND;
            end
            ST_ADMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_REJECT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready     = 1'b0;
        scan_issue  = 1'b0;
        scan_clr    = 1'b0;
        scan_rewind = 1'b0;
        admit_fire  = 1'b0;
        reject_fire = 1'b0;
        upd_retire  = 1'b0;
        upd_write   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                scan_clr = 1'b1;
            end
            ST_FIND: begin
                scan_issue = (scan_cnt_reg != SCAN_END);
            end
            ST_DECIDE: begin
                // keep least and free slot for the update pass and admission
                scan_rewind = 1'b1;
            end
            ST_UPDATE: begin
                scan_issue = (scan_cnt_reg != SCAN_END);
                scan_clr   = scan_done;
                upd_retire = p_vld_reg && act_q && (q_rem == least_reg);
                upd_write  = p_vld_reg && act_q && (q_rem != least_reg);
            end
            ST_ADMIT: begin
                admit_fire = out_free;
            end
            ST_REJECT: begin
                reject_fire = out_free;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        scan_cnt_next  = scan_cnt_reg;
        least_vld_next = least_vld_reg;
        least_next     = least_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        used_next      = used_reg;
        time_next      = time_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_start_next   = m_start_reg;
        m_rej_next     = m_rej_reg;
        mem_we         = 1'b0;
        mem_waddr      = p_idx_reg;
        mem_wdata      = {q_usage, q_rem - least_reg};

        if (scan_clr) begin
            scan_cnt_next  = '0;
            least_vld_next = 1'b0;
            free_vld_next  = 1'b0;
        end else if (scan_rewind) begin
            scan_cnt_next = '0;
        end else if (scan_issue) begin
            scan_cnt_next = scan_cnt_reg + CW'(1);
        end

        // search pass: least remaining time among active slots, lowest free slot
        if (state_reg == ST_FIND && p_vld_reg) begin
            if (act_q) begin
                if (!least_vld_reg || q_rem < least_reg) begin
                    least_vld_next = 1'b1;
                    least_next     = q_rem;
                end
            end else if (!free_vld_reg) begin
                free_vld_next = 1'b1;
                free_idx_next = p_idx_reg;
            end
        end

        // empty table always fits, drop any stale usage
        if (state_reg == ST_DECIDE && !fits && !least_vld_reg) begin
            used_next = '0;
        end

        if (upd_retire) begin
            used_next = (used_reg >= q_usage) ? used_reg - q_usage : '0;
        end
        if (upd_write) begin
            mem_we = 1'b1;
        end
        if (state_reg == ST_UPDATE && scan_done) begin
            time_next = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
        end

        if (admit_fire) begin
            mem_we       = 1'b1;
            mem_waddr    = free_idx_reg;
            mem_wdata    = {job_usage_reg, job_dur_reg};
            used_next    = used_reg + job_usage_reg;
            m_valid_next = 1'b1;
            m_start_next = time_reg;
            m_rej_next   = 1'b0;
        end
        if (reject_fire) begin
            m_valid_next = 1'b1;
            m_start_next = '0;
            m_rej_next   = 1'b1;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= slot_mem[scan_cnt_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            capacity_reg  <= CAPACITY_RESET;
            used_reg      <= '0;
            time_reg      <= '0;
            scan_cnt_reg  <= '0;
            p_vld_reg     <= 1'b0;
            least_vld_reg <= 1'b0;
            free_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            time_reg      <= time_next;
            scan_cnt_reg  <= scan_cnt_next;
            p_vld_reg     <= scan_issue;
            least_vld_reg <= least_vld_next;
            free_vld_reg  <= free_vld_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (upd_retire) begin
                active_reg[p_idx_reg] <= 1'b0;
            end
            if (admit_fire) begin
                active_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_idx_reg    <= scan_cnt_reg[IW-1:0];
        least_reg    <= least_next;
        free_idx_reg <= free_idx_next;
        m_start_reg  <= m_start_next;
        m_rej_reg    <= m_rej_next;
        if (in_fire) begin
            job_usage_reg <= s_job_usage;
            job_dur_reg   <= s_job_duration;
        end
    end

    // an oversized job goes straight to the reject path
    a_reject_path: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (s_job_usage > capacity_reg) |=> state_reg == ST_REJECT)
        else $error("oversized job not routed to reject");

    // admission always has a free slot picked by the search pass
    a_admit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADMIT |-> free_vld_reg && !active_reg[free_idx_reg])
        else $error("admit without a free slot");

    // least found by the search pass is a lower bound for every active slot
    a_least_min: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE && p_vld_reg && act_q |-> least_vld_reg && q_rem >= least_reg)
        else $error("update pass below least remaining time");

    // a rejected result reports time zero
    a_reject_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_rej_reg |-> m_start_reg == '0)
        else $error("rejected beat with nonzero start time");

    // results never overwrite a beat that is still waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !admit_fire && !reject_fire)
        else $error("result overwritten before taken");

endmodule

@@ sim/tb_capacity_admission_scheduler.sv @@
`timescale 1ns / 100ps

module tb_capacity_admission_scheduler;
    import cas_pkg::*;

    localparam int NUM_SLOTS = 128;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic              rejected;
    } admission_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [USAGE_W-1:0]  cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic [USAGE_W-1:0]  s_job_usage;
    logic [DUR_W-1:0]    s_job_duration;
    logic                m_valid;
    logic                m_ready;
    logic [TIME_W-1:0]   m_start_time;
    logic                m_rejected;

    // scheduler state as the testbench sees it
    logic [DUR_W-1:0]    slot_left [NUM_SLOTS];
    logic [USAGE_W-1:0]  slot_units [NUM_SLOTS];
    bit                  slot_on [NUM_SLOTS];
    logic [TIME_W-1:0]   clk_now = '0;
    logic [USAGE_W-1:0]  used_units = '0;
    logic [USAGE_W-1:0]  cap_model = CAPACITY_RESET;

    admission_t          admissions_q [$];
    int                  err_count = 0;
    int                  beat_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;

    capacity_admission_scheduler #(
        .SLOTS(NUM_SLOTS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_job_usage    (s_job_usage),
        .s_job_duration (s_job_duration),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_start_time   (m_start_time),
        .m_rejected     (m_rejected)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int first_free_slot();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_on[i])
                return i;
        end
        return -1;
    endfunction

    // reject an oversized job; else retire earliest finishers until it fits, then place it
    function automatic admission_t admit_job(logic [USAGE_W-1:0] usage, logic [DUR_W-1:0] dur);
        admission_t res;
        int slot;
        int freed;
        logic [31:0] least;
        res.start_time = '0;
        res.rejected   = 1'b0;
        if (usage > cap_model) begin
            res.rejected = 1'b1;
            return res;
        end
        slot = first_free_slot();
        for (int guard = 0; guard <= NUM_SLOTS; guard++) begin
            if (slot >= 0 && int'(used_units) + int'(usage) <= int'(cap_model))
                break;
            least = 32'h1_0000;
            foreach (slot_on[i]) begin
                if (slot_on[i] && {16'd0, slot_left[i]} < least)
                    least = {16'd0, slot_left[i]};
            end
            if (least > 32'hFFFF) begin
                used_units = '0;
                slot = first_free_slot();
                break;
            end
            freed = 0;
            foreach (slot_on[i]) begin
                if (slot_on[i]) begin
                    if ({16'd0, slot_left[i]} == least) begin
                        slot_on[i] = 1'b0;
                        freed += int'(slot_units[i]);
                    end else begin
                        slot_left[i] = slot_left[i] - least[DUR_W-1:0];
                    end
                end
            end
            used_units = (freed >= int'(used_units)) ? '0 : used_units - freed[USAGE_W-1:0];
            clk_now = (clk_now > TIME_MAX - least) ? TIME_MAX : clk_now + least;
            slot = first_free_slot();
        end
        if (slot < 0)
            slot = 0;
        slot_on[slot]    = 1'b1;
        slot_left[slot]  = dur;
        slot_units[slot] = usage;
        used_units       = used_units + usage;
        res.start_time   = clk_now;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        $display("ERROR beat %0d: %s expected %0d got %0d (t=%0t)",
                 beat_count, what, want, got, $realtime);
        err_count++;
    endtask

    task automatic send_job(logic [USAGE_W-1:0] usage, logic [DUR_W-1:0] dur);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_job_usage    <= usage;
        s_job_duration <= dur;
        do @(posedge aclk); while (!s_ready);
        admissions_q.push_back(admit_job(usage, dur));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (admissions_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [USAGE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_model = value;
    endtask

    task automatic send_random_jobs(int count);
        logic [USAGE_W-1:0] usage;
        logic [DUR_W-1:0] dur;
        int pick;
        for (int n = 0; n < count; n++) begin
            // mostly jobs that fit, a few oversized ones
            if ($urandom_range(99) < 12)
                usage = USAGE_W'($urandom_range(255));
            else
                usage = USAGE_W'($urandom_range(int'(cap_model)));
            pick = $urandom_range(99);
            // short durations produce ties and zero-length jobs
            if (pick < 15)
                dur = DUR_W'($urandom_range(3));
            else if (pick < 25)
                dur = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            else if (pick < 50)
                dur = DUR_W'($urandom_range(255));
            else
                dur = DUR_W'($urandom_range(16'hFFFF));
            send_job(usage, dur);
        end
    endtask

    task automatic test_reset_capacity();
        send_job(8'd0, 16'd0);
        send_job(8'd100, 16'hFFFF);
        send_job(8'd101, 16'd1);
        send_job(8'd255, 16'hFFFF);
        send_job(8'd1, 16'd5);
        send_job(8'd50, 16'd0);
        send_job(8'd49, 16'd0);
        send_job(8'd0, 16'd3);
        send_job(8'd1, 16'd7);
        send_job(8'h55, 16'h5555);
    endtask

    task automatic test_capacity_extremes();
        wait_idle();
        set_capacity(8'd255);
        send_job(8'd255, 16'h00FF);
        send_job(8'd0, 16'hFF00);
        send_job(8'd255, 16'd1);
        wait_idle();
        set_capacity(8'd1);
        send_job(8'd2, 16'd0);
        send_job(8'd1, 16'h1234);
        send_job(8'd1, 16'd0);
        send_job(8'd0, 16'd1);
    endtask

    // capacity drops under the usage already held
    task automatic test_capacity_lowered();
        wait_idle();
        set_capacity(8'd200);
        send_job(8'd120, 16'd300);
        send_job(8'd80, 16'd1000);
        wait_idle();
        set_capacity(8'd50);
        send_job(8'd10, 16'd7);
        send_job(8'd40, 16'd2);
        send_job(8'd0, 16'd0);
    endtask

    task automatic test_table_full();
        wait_idle();
        set_capacity(8'd255);
        for (int n = 0; n < 140; n++)
            send_job(USAGE_W'($urandom_range(1)), DUR_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic test_random_traffic(int batches);
        logic [USAGE_W-1:0] cap;
        for (int b = 0; b < batches; b++) begin
            wait_idle();
            case (b % 5)
                3: begin
                    cap = 8'd255;
                end
                4: begin
                    cap = USAGE_W'($urandom_range(1, 4));
                end
                default: begin
                    cap = USAGE_W'($urandom_range(1, 255));
                end
            endcase
            set_capacity(cap);
            send_random_jobs(50);
        end
    endtask

    // result side: random backpressure and field checks
    always @(posedge aclk) begin
        admission_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (admissions_q.size() == 0) begin
                    report_mismatch("unexpected beat, start_time", '0, m_start_time);
                end else begin
                    want = admissions_q.pop_front();
                    if (m_start_time !== want.start_time)
                        report_mismatch("start_time", want.start_time, m_start_time);
                    if (m_rejected !== want.rejected)
                        report_mismatch("rejected", TIME_W'(want.rejected),
                                        TIME_W'(m_rejected));
                end
                beat_count++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_job_usage    <= '0;
        s_job_duration <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 36;
        recv_idle_pct = 83;
        test_reset_capacity();
        test_capacity_extremes();
        test_capacity_lowered();
        test_table_full();

        send_idle_pct = 83;
        recv_idle_pct = 36;
        test_random_traffic(5);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(6);

        wait_idle();
        repeat (2 * NUM_SLOTS + 8) @(posedge aclk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", admissions_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
